### rtl/assert_macros.svh
// Assertion macros for the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/bvs_pkg.sv
// Types and constants of the battery voltage supervisor.
package bvs_pkg;

	localparam int SAMPLE_W = 10;
	localparam int LEVEL_W  = 10;
	localparam int CAL_W    = 11;
	localparam int DVD_W    = 19;
	localparam int DIVR_W   = 9;
	localparam int CNT_W    = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic [DIVR_W-1:0] REF_NOMINAL = 9'd472;
	localparam logic [LEVEL_W-1:0] REF_LOW    = 10'd439;
	localparam logic [LEVEL_W-1:0] REF_HIGH   = 10'd505;
	localparam logic [11:0] SAMPLE_MAX        = 12'd1023;

	localparam logic signed [CNT_W-1:0] DEBOUNCE_START = 5'sd9;
	localparam logic signed [CNT_W-1:0] CNT_STEP_DOWN  = 5'sd3;
	localparam logic signed [CNT_W-1:0] CNT_STEP_UP    = 5'sd3;
	localparam logic signed [CNT_W-1:0] CNT_STEP_OVER  = 5'sd2;

	localparam logic [LEVEL_W-1:0] RST_REFERENCE  = 10'd472;
	localparam logic [LEVEL_W-1:0] RST_UNDER_ENT  = 10'd163;
	localparam logic [LEVEL_W-1:0] RST_UNDER_EXIT = 10'd173;
	localparam logic [LEVEL_W-1:0] RST_VLOW       = 10'd140;
	localparam logic [LEVEL_W-1:0] RST_VLOW_EXIT  = 10'd157;
	localparam logic [LEVEL_W-1:0] RST_OVER_ENT   = 10'd524;
	localparam logic [LEVEL_W-1:0] RST_OVER_EXIT  = 10'd508;

	typedef enum logic [1:0] {
		BAT_NORMAL = 2'd0,
		BAT_UNDER  = 2'd1,
		BAT_OVER   = 2'd2,
		BAT_RESET  = 2'd3
	} bat_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REFERENCE  = 3'd0,
		CFG_UNDER_ENT  = 3'd1,
		CFG_UNDER_EXIT = 3'd2,
		CFG_VLOW       = 3'd3,
		CFG_VLOW_EXIT  = 3'd4,
		CFG_OVER_ENT   = 3'd5,
		CFG_OVER_EXIT  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### rtl/bvs_div.sv
// Bit-serial restoring divider for the gain calibration.
module bvs_div
	import bvs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [DIVR_W-1:0] divisor,
	output div_stat_t         stat,
	output logic [CAL_W-1:0]  quotient
);

	localparam logic [4:0] LAST_STEP = 5'(DVD_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] divr_q;
	logic [DVD_W-1:0]  dvd_q;

	logic [DIVR_W:0] trial;
	logic [DIVR_W:0] diff;
	logic            ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, divr_q};
	assign ge    = trial >= {1'b0, divr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			divr_q <= divisor;
			dvd_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q[CAL_W-1:0];

endmodule

### rtl/battery_voltage_supervisor_unit.sv
// Battery voltage supervisor: gain calibration and debounced four-state monitor.
// Each item passes through the bit-serial divider (19 steps) before its result is registered.
// A new item is accepted only after the previous result has entered the output register.
// The input stalls while a division runs or a result waits for the output register.
// Reset: state under-voltage, supply not started, debounce count 9, levels to defaults.
module battery_voltage_supervisor_unit
	import bvs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SAMPLE_W-1:0]  adc_sample,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           battery_status,
	output logic                 supply_ok,
	output logic [SAMPLE_W-1:0]  calibrated_sample,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEVEL_W-1:0]   cfg_data
);

	`include "assert_macros.svh"

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_WAIT
	} fsm_t;

	fsm_t fsm_q;

	logic [LEVEL_W-1:0] ref_q, under_ent_q, under_exit_q, vlow_q, vlow_exit_q;
	logic [LEVEL_W-1:0] over_ent_q, over_exit_q;

	bat_state_t               bat_q;
	logic                     started_q;
	logic signed [CNT_W-1:0]  cnt_q;
	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic                     ok_q;
	logic [SAMPLE_W-1:0]      cal_out_q;

	logic                     start;
	logic [DVD_W-1:0]         dividend;
	logic [DIVR_W-1:0]        divisor;
	div_stat_t                div_st;
	logic [CAL_W-1:0]         quotient;
	logic [CAL_W-1:0]         cal;
	bat_state_t               cur_bat;
	bat_state_t               nxt_bat;
	logic signed [CNT_W-1:0]  cnt_dn;
	logic signed [CNT_W-1:0]  nxt_cnt;
	logic                     fire;
	logic                     out_free;
	logic                     load_out;

	assign cfg_ready = 1'b1;
	assign in_stall  = (fsm_q != S_IDLE);
	assign start     = in_valid && (fsm_q == S_IDLE);
	assign dividend  = DVD_W'(adc_sample) * DVD_W'(REF_NOMINAL);
	assign divisor   = (ref_q < REF_LOW || ref_q > REF_HIGH) ? REF_NOMINAL
		: ref_q[DIVR_W-1:0];

	bvs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (dividend),
		.divisor  (divisor),
		.stat     (div_st),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q        <= RST_REFERENCE;
			under_ent_q  <= RST_UNDER_ENT;
			under_exit_q <= RST_UNDER_EXIT;
			vlow_q       <= RST_VLOW;
			vlow_exit_q  <= RST_VLOW_EXIT;
			over_ent_q   <= RST_OVER_ENT;
			over_exit_q  <= RST_OVER_EXIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_REFERENCE:  ref_q        <= cfg_data;
				CFG_UNDER_ENT:  under_ent_q  <= cfg_data;
				CFG_UNDER_EXIT: under_exit_q <= cfg_data;
				CFG_VLOW:       vlow_q       <= cfg_data;
				CFG_VLOW_EXIT:  vlow_exit_q  <= cfg_data;
				CFG_OVER_ENT:   over_ent_q   <= cfg_data;
				CFG_OVER_EXIT:  over_exit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cal = ({1'b0, quotient} > SAMPLE_MAX) ? SAMPLE_MAX[CAL_W-1:0] : quotient;
		cur_bat = started_q ? bat_q : BAT_UNDER;
		cnt_dn  = cnt_q - CNT_STEP_DOWN;
		fire    = (cnt_dn <= 5'sd0);
		nxt_bat = cur_bat;
		nxt_cnt = cnt_q;
		case (cur_bat)
			BAT_NORMAL: begin
				if (cal < CAL_W'(under_ent_q)) begin
					nxt_cnt = fire ? DEBOUNCE_START : cnt_dn;
					if (fire) nxt_bat = BAT_UNDER;
				end else if (cal > CAL_W'(over_ent_q)) begin
					nxt_cnt = fire ? DEBOUNCE_START : cnt_dn;
					if (fire) nxt_bat = BAT_OVER;
				end else if (cnt_q < DEBOUNCE_START) begin
					nxt_cnt = cnt_q + CNT_STEP_UP;
				end
			end
			BAT_UNDER: begin
				if (cal > CAL_W'(under_exit_q)) begin
					nxt_cnt = fire ? DEBOUNCE_START : cnt_dn;
					if (fire) nxt_bat = BAT_NORMAL;
				end else if (cal < CAL_W'(vlow_q)) begin
					nxt_cnt = fire ? DEBOUNCE_START : cnt_dn;
					if (fire) nxt_bat = BAT_RESET;
				end else if (cnt_q < DEBOUNCE_START) begin
					nxt_cnt = cnt_q + CNT_STEP_UP;
				end
			end
			BAT_RESET: begin
				if (cal > CAL_W'(vlow_exit_q)) begin
					nxt_cnt = fire ? DEBOUNCE_START : cnt_dn;
				end else if (cnt_q < DEBOUNCE_START) begin
					nxt_cnt = cnt_q + CNT_STEP_UP;
				end
			end
			default: begin
				if (cal < CAL_W'(over_exit_q)) begin
					nxt_cnt = fire ? DEBOUNCE_START : cnt_dn;
					if (fire) nxt_bat = BAT_NORMAL;
				end else if (cnt_q < DEBOUNCE_START) begin
					nxt_cnt = cnt_q + CNT_STEP_OVER;
				end
			end
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign load_out = ((fsm_q == S_DIV && div_st.done) || fsm_q == S_WAIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= S_IDLE;
			bat_q       <= BAT_UNDER;
			started_q   <= 1'b0;
			cnt_q       <= DEBOUNCE_START;
			out_valid_q <= 1'b0;
			status_q    <= '0;
			ok_q        <= 1'b0;
			cal_out_q   <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (fsm_q)
				S_IDLE: begin
					if (in_valid) fsm_q <= S_DIV;
				end
				S_DIV, S_WAIT: begin
					if (fsm_q == S_WAIT || div_st.done) begin
						if (out_free) begin
							bat_q       <= nxt_bat;
							cnt_q       <= nxt_cnt;
							started_q   <= 1'b1;
							status_q    <= nxt_bat;
							ok_q        <= (nxt_bat == BAT_NORMAL);
							cal_out_q   <= cal[SAMPLE_W-1:0];
							fsm_q       <= S_IDLE;
						end else begin
							fsm_q <= S_WAIT;
						end
					end
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign battery_status    = status_q;
	assign supply_ok         = ok_q;
	assign calibrated_sample = cal_out_q;

	`ASSERT_NEXT(a_stall_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`ASSERT_NOW(a_div_busy_in_div, clk, arst_n, div_st.busy, fsm_q == S_DIV)
	`ASSERT_NOW(a_cnt_range, clk, arst_n, 1'b1, cnt_q >= -5'sd2 && cnt_q <= 5'sd14)
	`ASSERT_NEXT(a_reset_sticky, clk, arst_n, started_q && bat_q == BAT_RESET, bat_q == BAT_RESET)
	`ASSERT_NOW(a_ok_normal, clk, arst_n, out_valid && supply_ok, battery_status == BAT_NORMAL)

endmodule

### test/battery_voltage_supervisor_unit_test.sv
// Self-checking testbench of the battery voltage supervisor with its own state predictor.
`timescale 1ns / 1ps

module battery_voltage_supervisor_unit_test;
	import bvs_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int VLOW_CAP = 956;

	typedef struct packed {
		bat_state_t status;
		logic ok;
		logic [SAMPLE_W-1:0] cal;
	} bat_result_t;

	typedef enum logic [1:0] {BAND_LOW, BAND_INSIDE, BAND_HIGH} band_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [SAMPLE_W-1:0] adc_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] battery_status;
	logic supply_ok;
	logic [SAMPLE_W-1:0] calibrated_sample;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEVEL_W-1:0] cfg_data = '0;

	logic [LEVEL_W-1:0] levels [0:6];
	bat_state_t mon_state;
	logic started;
	logic signed [CNT_W-1:0] debounce;

	bat_result_t expected_readings [$];
	int mismatches = 0;
	int quiet = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_off_req = 0;
	int hold_left = 0;
	band_t run_band = BAND_INSIDE;
	int run_left = 0;

	battery_voltage_supervisor_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.adc_sample(adc_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.battery_status(battery_status),
		.supply_ok(supply_ok),
		.calibrated_sample(calibrated_sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned effective_divisor();
		if (levels[CFG_REFERENCE] < REF_LOW || levels[CFG_REFERENCE] > REF_HIGH)
			return 32'(REF_NOMINAL);
		return 32'(levels[CFG_REFERENCE]);
	endfunction

	function automatic logic [SAMPLE_W-1:0] calibrate_reading(input logic [SAMPLE_W-1:0] s);
		int unsigned q;
		q = 32'(s);
		q = q * 32'(REF_NOMINAL) / effective_divisor();
		if (q > 32'(SAMPLE_MAX))
			q = 32'(SAMPLE_MAX);
		return q[SAMPLE_W-1:0];
	endfunction

	function automatic logic debounce_expired();
		debounce = debounce - CNT_STEP_DOWN;
		if (debounce <= 5'sd0) begin
			debounce = DEBOUNCE_START;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void debounce_recover(input logic signed [CNT_W-1:0] step);
		if (debounce < DEBOUNCE_START)
			debounce = debounce + step;
	endfunction

	function automatic bat_result_t predict_reading(input logic [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] cal;
		bat_result_t r;
		cal = calibrate_reading(s);
		if (!started) begin
			started = 1'b1;
			mon_state = BAT_UNDER;
		end
		case (mon_state)
			BAT_NORMAL: begin
				if (cal < levels[CFG_UNDER_ENT]) begin
					if (debounce_expired())
						mon_state = BAT_UNDER;
				end else if (cal > levels[CFG_OVER_ENT]) begin
					if (debounce_expired())
						mon_state = BAT_OVER;
				end else begin
					debounce_recover(CNT_STEP_UP);
				end
			end
			BAT_UNDER: begin
				if (cal > levels[CFG_UNDER_EXIT]) begin
					if (debounce_expired())
						mon_state = BAT_NORMAL;
				end else if (cal < levels[CFG_VLOW]) begin
					if (debounce_expired())
						mon_state = BAT_RESET;
				end else begin
					debounce_recover(CNT_STEP_UP);
				end
			end
			BAT_RESET: begin
				if (cal > levels[CFG_VLOW_EXIT])
					void'(debounce_expired());
				else
					debounce_recover(CNT_STEP_UP);
			end
			default: begin
				if (cal < levels[CFG_OVER_EXIT]) begin
					if (debounce_expired())
						mon_state = BAT_NORMAL;
				end else begin
					debounce_recover(CNT_STEP_OVER);
				end
			end
		endcase
		r.status = mon_state;
		r.ok = started && mon_state == BAT_NORMAL;
		r.cal = cal;
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] raw_for(input int unsigned target);
		int unsigned s;
		s = (target * effective_divisor() + 32'(REF_NOMINAL) - 32'd1) / 32'(REF_NOMINAL);
		if (s > 32'(SAMPLE_MAX))
			s = 32'(SAMPLE_MAX);
		return s[SAMPLE_W-1:0];
	endfunction

	// Runs of same-band samples drive the debounce through; avoid locking into reset-pending.
	function automatic logic [SAMPLE_W-1:0] next_random_sample();
		int unsigned lo, hi, target;
		logic [SAMPLE_W-1:0] s, cal;
		case (mon_state)
			BAT_NORMAL: begin
				lo = 32'(levels[CFG_UNDER_ENT]);
				hi = 32'(levels[CFG_OVER_ENT]);
			end
			BAT_UNDER: begin
				lo = 32'(levels[CFG_VLOW]);
				hi = 32'(levels[CFG_UNDER_EXIT]);
			end
			BAT_OVER: begin
				lo = 32'(levels[CFG_OVER_EXIT]);
				hi = 32'(SAMPLE_MAX);
			end
			default: begin
				lo = 0;
				hi = 32'(levels[CFG_VLOW_EXIT]);
			end
		endcase
		if (run_left == 0) begin
			run_band = band_t'($urandom_range(2));
			run_left = $urandom_range(5, 1);
		end
		run_left--;
		if ($urandom_range(99) < 15) begin
			s = SAMPLE_W'($urandom_range(SAMPLE_MAX));
		end else begin
			case (run_band)
				BAND_LOW: target = (lo > 0) ? $urandom_range(lo - 1) : lo;
				BAND_HIGH: target = (hi < 32'(SAMPLE_MAX))
					? $urandom_range(SAMPLE_MAX, hi + 1) : hi;
				default: target = (lo <= hi) ? $urandom_range(hi, lo)
					: $urandom_range(SAMPLE_MAX);
			endcase
			s = raw_for(target);
		end
		cal = calibrate_reading(s);
		if (mon_state == BAT_UNDER && debounce <= CNT_STEP_DOWN && cal < levels[CFG_VLOW]
				&& !(cal > levels[CFG_UNDER_EXIT]))
			s = raw_for(32'(levels[CFG_VLOW]));
		return s;
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_readings.push_back(predict_reading(s));
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_level(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx <= CFG_OVER_EXIT)
			levels[idx] = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_levels(input logic [LEVEL_W-1:0] ref_v, ue, ux, vl, vx, oe, ox);
		write_level(CFG_REFERENCE, ref_v);
		write_level(CFG_UNDER_ENT, ue);
		write_level(CFG_UNDER_EXIT, ux);
		write_level(CFG_VLOW, vl);
		write_level(CFG_VLOW_EXIT, vx);
		write_level(CFG_OVER_ENT, oe);
		write_level(CFG_OVER_EXIT, ox);
	endtask

	task automatic randomize_levels();
		int unsigned ue, vl, oe;
		if ($urandom_range(3) == 0) begin
			write_levels(LEVEL_W'($urandom_range(SAMPLE_MAX)),
				LEVEL_W'($urandom_range(SAMPLE_MAX)),
				LEVEL_W'($urandom_range(SAMPLE_MAX)), LEVEL_W'($urandom_range(VLOW_CAP)),
				LEVEL_W'($urandom_range(SAMPLE_MAX)), LEVEL_W'($urandom_range(SAMPLE_MAX)),
				LEVEL_W'($urandom_range(SAMPLE_MAX)));
		end else begin
			ue = $urandom_range(400, 100);
			vl = ue - $urandom_range(60);
			oe = $urandom_range(900, 450);
			write_levels(($urandom_range(3) == 0) ? LEVEL_W'($urandom_range(SAMPLE_MAX))
				: LEVEL_W'($urandom_range(REF_HIGH, REF_LOW)), LEVEL_W'(ue),
				LEVEL_W'(ue + $urandom_range(40)), LEVEL_W'(vl),
				LEVEL_W'(vl + $urandom_range(30)), LEVEL_W'(oe),
				LEVEL_W'(oe - $urandom_range(40)));
		end
		if ($urandom_range(3) == 0)
			write_level(CFG_UNUSED, LEVEL_W'($urandom_range(SAMPLE_MAX)));
	endtask

	task automatic set_idle(input int sender_pct, input int receiver_pct);
		sender_idle_pct = sender_pct;
		receiver_stall_pct = receiver_pct;
	endtask

	task automatic test_startup_and_extremes();
		int k;
		set_idle(0, 0);
		send_sample(10'd0);
		send_sample(10'd1023);
		for (k = 0; k < 3; k++)
			send_sample(10'd160);
		settle();
	endtask

	task automatic test_state_walk();
		int k;
		for (k = 0; k < 3; k++)
			send_sample(10'd300);
		for (k = 0; k < 3; k++)
			send_sample(10'd600);
		send_sample(10'd520);
		send_sample(10'd400);
		send_sample(10'd520);
		for (k = 0; k < 3; k++)
			send_sample(10'd400);
		for (k = 0; k < 3; k++)
			send_sample(10'd100);
		settle();
	endtask

	task automatic test_reference_window();
		int refs [7] = '{0, 438, 439, 472, 505, 506, 1023};
		int i;
		for (i = 0; i < 7; i++) begin
			write_level(CFG_REFERENCE, LEVEL_W'(refs[i]));
			repeat (8) send_sample(next_random_sample());
			settle();
		end
	endtask

	task automatic test_level_extremes();
		write_levels(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
		repeat (25) send_sample(next_random_sample());
		settle();
		write_levels(10'd1023, 10'd1023, 10'd1023, LEVEL_W'(VLOW_CAP), 10'd1023, 10'd1023,
			10'd1023);
		repeat (25) send_sample(next_random_sample());
		settle();
		// overlapping levels: the under test wins in normal, recovery wins in under
		write_levels(RST_REFERENCE, 10'd1023, 10'd0, LEVEL_W'(VLOW_CAP), 10'd0, 10'd0,
			10'd1023);
		repeat (25) send_sample(next_random_sample());
		settle();
	endtask

	task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
		set_idle(sender_pct, receiver_pct);
		repeat (5) begin
			randomize_levels();
			repeat (50) send_sample(next_random_sample());
			settle();
		end
	endtask

	task automatic test_backpressure();
		set_idle(0, 0);
		randomize_levels();
		hold_off_req = HOLD_OFF_CYCLES;
		repeat (40) send_sample(next_random_sample());
		settle();
	endtask

	task automatic test_reset_pending();
		int k;
		set_idle(28, 28);
		write_levels(RST_REFERENCE, RST_UNDER_ENT, RST_UNDER_EXIT, RST_VLOW, RST_VLOW_EXIT,
			RST_OVER_ENT, RST_OVER_EXIT);
		for (k = 0; k < 20 && mon_state != BAT_RESET; k++)
			send_sample(10'd0);
		repeat (30) send_sample(next_random_sample());
		settle();
		write_levels(RST_REFERENCE, RST_UNDER_ENT, RST_UNDER_EXIT, 10'd1023, 10'd0,
			RST_OVER_ENT, RST_OVER_EXIT);
		repeat (25) send_sample(next_random_sample());
		settle();
		write_level(CFG_VLOW_EXIT, 10'd1023);
		repeat (25) send_sample(next_random_sample());
		settle();
	endtask

	always @(negedge clk) begin
		if (hold_off_req != 0) begin
			hold_left = hold_off_req;
			hold_off_req = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= $urandom_range(99) < receiver_stall_pct;
		end
	end

	always @(posedge clk) begin
		bat_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				$error("result with no sample pending: status %0d", battery_status);
				mismatches++;
			end else begin
				want = expected_readings.pop_front();
				if (battery_status !== want.status) begin
					$error("battery_status: expected %0d, got %0d", want.status, battery_status);
					mismatches++;
				end
				if (supply_ok !== want.ok) begin
					$error("supply_ok: expected %0d, got %0d", want.ok, supply_ok);
					mismatches++;
				end
				if (calibrated_sample !== want.cal) begin
					$error("calibrated_sample: expected %0d, got %0d", want.cal,
						calibrated_sample);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		levels[CFG_REFERENCE] = RST_REFERENCE;
		levels[CFG_UNDER_ENT] = RST_UNDER_ENT;
		levels[CFG_UNDER_EXIT] = RST_UNDER_EXIT;
		levels[CFG_VLOW] = RST_VLOW;
		levels[CFG_VLOW_EXIT] = RST_VLOW_EXIT;
		levels[CFG_OVER_ENT] = RST_OVER_ENT;
		levels[CFG_OVER_EXIT] = RST_OVER_EXIT;
		mon_state = BAT_UNDER;
		started = 1'b0;
		debounce = DEBOUNCE_START;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_startup_and_extremes();
		test_state_walk();
		test_reference_window();
		test_level_extremes();
		test_random_traffic(0, 0);
		test_random_traffic(87, 0);
		test_random_traffic(0, 87);
		test_random_traffic(28, 28);
		test_backpressure();
		test_reset_pending();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
